[hw/rtl/nnis_pkg.sv]
// Shared constants, types and tables of the nearest-neighbor image scaler.
`default_nettype none

package nnis_pkg;

    // Frame store geometry and sample width.
    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_BITS = 8;

    localparam int COL_BITS   = $clog2(MAX_WIDTH);
    localparam int ROW_BITS   = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_BITS + ROW_BITS;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    // Field widths of the items and registers.
    localparam int COORD_W  = 12;
    localparam int FACTOR_W = 5;
    localparam int SIZE_W   = 9;
    localparam int IDX_W    = 2;
    localparam int DATA_W   = 9;

    localparam int MAX_FACTOR = 16;

    // Division by the factor is a multiply by a rounded-up reciprocal of
    // 2^RECIP_SHIFT / f. With 2^5 >= MAX_FACTOR and 12-bit coordinates the
    // quotient is exact.
    localparam int RECIP_SHIFT = COORD_W + FACTOR_W;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = COORD_W + RECIP_W;
    localparam int SRC_W       = COORD_W + FACTOR_W;

    localparam logic [RECIP_W-1:0] RECIP_TABLE [0:MAX_FACTOR] = '{
        RECIP_W'(131072), RECIP_W'(131072), RECIP_W'(65536), RECIP_W'(43691),
        RECIP_W'(32768),  RECIP_W'(26215),  RECIP_W'(21846), RECIP_W'(18725),
        RECIP_W'(16384),  RECIP_W'(14564),  RECIP_W'(13108), RECIP_W'(11916),
        RECIP_W'(10923),  RECIP_W'(10083),  RECIP_W'(9363),  RECIP_W'(8739),
        RECIP_W'(8192)
    };

    // Item function codes.
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Configuration register indexes.
    localparam logic [IDX_W-1:0] REG_SCALE_FACTOR  = 2'd0;
    localparam logic [IDX_W-1:0] REG_REDUCE_MODE   = 2'd1;
    localparam logic [IDX_W-1:0] REG_SOURCE_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_SOURCE_HEIGHT = 2'd3;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } pixel_t;

    // Operand setup handed to the coordinate mapper.
    typedef struct packed {
        logic               reduce;
        logic [RECIP_W-1:0] mult;
    } scale_t;

    // Mapped source coordinate and its range flag.
    typedef struct packed {
        logic [ROW_BITS-1:0] row;
        logic [COL_BITS-1:0] col;
        logic                oor;
    } map_t;

    // Linear frame store address of a source pixel.
    function automatic logic [ADDR_W-1:0] pix_addr(input logic [ROW_BITS-1:0] r,
                                                   input logic [COL_BITS-1:0] c);
        pix_addr = ADDR_W'(r) * ADDR_W'(MAX_WIDTH) + ADDR_W'(c);
    endfunction

endpackage

`default_nettype wire

[hw/rtl/nnis_if.sv]
// Handshake channel interfaces of the image scaler: pixel requests, results, configuration.
`default_nettype none

interface nnis_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 func;
    logic [nnis_pkg::COORD_W-1:0]         row;
    logic [nnis_pkg::COORD_W-1:0]         col;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    red_in;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    green_in;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    blue_in;

    modport source (output valid, func, row, col, red_in, green_in, blue_in,
                    input ready);
    modport sink   (input valid, func, row, col, red_in, green_in, blue_in,
                    output ready);
endinterface

interface nnis_rsp_if;
    logic                                 valid;
    logic                                 ready;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    red_out;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    green_out;
    logic [nnis_pkg::CHANNEL_BITS-1:0]    blue_out;
    logic                                 out_of_range;

    modport source (output valid, red_out, green_out, blue_out, out_of_range,
                    input ready);
    modport sink   (input valid, red_out, green_out, blue_out, out_of_range,
                    output ready);
endinterface

interface nnis_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [nnis_pkg::IDX_W-1:0]         index;
    logic [nnis_pkg::DATA_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

[hw/rtl/nearest_neighbor_image_scaler.sv]
// Top level of the nearest-neighbor image scaler: frame store, control and result register.
`default_nettype none

// The block holds one RGB source image of up to 256 by 256 pixels in a single
// synchronous memory and serves pixels of an integer-scaled version of it. A
// request item with func set to write stores its samples at (row, col) of the
// source image; writes outside the configured source size are dropped and give
// no result. A request item with func set to read names a pixel of the scaled
// image and gives exactly one result item: in enlarge mode the source pixel at
// (row / f, col / f), in reduce mode the one at (row * f, col * f), where the
// reduced image is rounded up to ceil(W / f) by ceil(H / f). A read outside the
// scaled image returns zero samples with out_of_range set. A factor of 0 acts as
// 1, one above 16 as 16, and sizes above 256 as 256. The frame store is not
// cleared at reset, so a read of a pixel that was never written returns
// whatever the memory holds. A write is stored at acceptance and does not
// hold up the next item. A read passes through the coordinate multiply, the
// memory read and the load of the result register, which waits until that
// register is free; the next item is accepted in the cycle after the result
// is loaded. The result register lets a new item enter while the last
// result waits on a stalled sink. Configuration writes are always accepted and
// must only be made while no read is in flight.
module nearest_neighbor_image_scaler (
    input  wire logic   clk,
    input  wire logic   rst_n,
    nnis_req_if.sink    req,
    nnis_rsp_if.source  rsp,
    nnis_cfg_if.sink    cfg
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MAP  = 3'b010,
        S_DATA = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers, kept as written.
    logic [nnis_pkg::FACTOR_W-1:0] factor_reg;
    logic                          reduce_reg;
    logic [nnis_pkg::SIZE_W-1:0]   width_reg;
    logic [nnis_pkg::SIZE_W-1:0]   height_reg;

    // Effective values after the clamping rules.
    logic [nnis_pkg::FACTOR_W-1:0] factor_eff;
    logic [nnis_pkg::SIZE_W-1:0]   width_eff;
    logic [nnis_pkg::SIZE_W-1:0]   height_eff;
    nnis_pkg::scale_t              scale;

    logic                          req_fire;
    logic                          rsp_fire;
    logic                          out_free;
    logic                          wr_en;
    logic [nnis_pkg::ADDR_W-1:0]   wr_addr;
    nnis_pkg::pixel_t              wr_data;
    logic                          rd_en;
    logic [nnis_pkg::ADDR_W-1:0]   rd_addr;
    nnis_pkg::pixel_t              rd_data_reg;
    logic                          oor_reg;
    nnis_pkg::map_t                map;

    // Result register.
    logic                          out_vld_reg;
    nnis_pkg::pixel_t              out_pix_reg;
    logic                          out_oor_reg;

    nnis_pkg::pixel_t              frame_mem [nnis_pkg::STORE_DEPTH];

    // ------------------------------------------------------------------
    // Configuration port. Writes land directly in the registers, so ready stays high.
    // ------------------------------------------------------------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= nnis_pkg::FACTOR_W'(1);
            reduce_reg <= 1'b0;
            width_reg  <= nnis_pkg::SIZE_W'(256);
            height_reg <= nnis_pkg::SIZE_W'(256);
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                nnis_pkg::REG_SCALE_FACTOR:
                    factor_reg <= cfg.data[nnis_pkg::FACTOR_W-1:0];
                nnis_pkg::REG_REDUCE_MODE:
                    reduce_reg <= cfg.data[0];
                nnis_pkg::REG_SOURCE_WIDTH:
                    width_reg  <= cfg.data[nnis_pkg::SIZE_W-1:0];
                nnis_pkg::REG_SOURCE_HEIGHT:
                    height_reg <= cfg.data[nnis_pkg::SIZE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        if (factor_reg == '0)
            factor_eff = nnis_pkg::FACTOR_W'(1);
        else if (factor_reg > nnis_pkg::FACTOR_W'(nnis_pkg::MAX_FACTOR))
            factor_eff = nnis_pkg::FACTOR_W'(nnis_pkg::MAX_FACTOR);
        else
            factor_eff = factor_reg;
    end

    assign width_eff  = (width_reg > nnis_pkg::SIZE_W'(nnis_pkg::MAX_WIDTH)) ?
                        nnis_pkg::SIZE_W'(nnis_pkg::MAX_WIDTH) : width_reg;
    assign height_eff = (height_reg > nnis_pkg::SIZE_W'(nnis_pkg::MAX_HEIGHT)) ?
                        nnis_pkg::SIZE_W'(nnis_pkg::MAX_HEIGHT) : height_reg;

    // Enlarging divides by the factor through its reciprocal; reducing
    // multiplies by the factor directly.
    assign scale.reduce = reduce_reg;
    assign scale.mult   = reduce_reg ? nnis_pkg::RECIP_W'(factor_eff)
                                     : nnis_pkg::RECIP_TABLE[factor_eff];

    // ------------------------------------------------------------------
    // Request side. Writes go straight to the frame store at acceptance;
    // reads start the mapping sequence.
    // ------------------------------------------------------------------
    assign req.ready = (state_reg == S_IDLE);
    assign req_fire  = req.valid && req.ready;

    assign wr_en = req_fire && (req.func == nnis_pkg::FUNC_WRITE) &&
                   (req.row < nnis_pkg::COORD_W'(height_eff)) &&
                   (req.col < nnis_pkg::COORD_W'(width_eff));
    assign wr_addr = nnis_pkg::pix_addr(req.row[nnis_pkg::ROW_BITS-1:0],
                                        req.col[nnis_pkg::COL_BITS-1:0]);
    assign wr_data = '{red: req.red_in, green: req.green_in, blue: req.blue_in};

    nnis_map u_map (
        .clk    (clk),
        .load   (req_fire),
        .row    (req.row),
        .col    (req.col),
        .scale  (scale),
        .src_w  (width_eff),
        .src_h  (height_eff),
        .result (map)
    );

    // Only in-range coordinates touch the memory; out-of-range reads are
    // answered from the flag alone.
    assign rd_en   = (state_reg == S_MAP) && !map.oor;
    assign rd_addr = nnis_pkg::pix_addr(map.row, map.col);

    always_ff @(posedge clk)
    begin
        if (wr_en)
            frame_mem[wr_addr] <= wr_data;
        if (rd_en)
            rd_data_reg <= frame_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_MAP)
            oor_reg <= map.oor;
    end

    // ------------------------------------------------------------------
    // Sequencer.
    // ------------------------------------------------------------------
    assign rsp_fire = out_vld_reg && rsp.ready;
    assign out_free = !out_vld_reg || rsp.ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire && (req.func == nnis_pkg::FUNC_READ))
                    state_next = S_MAP;
            end
            S_MAP:
                state_next = S_DATA;
            S_DATA:
            begin
                // Hold the fetched pixel until the result register is free.
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if ((state_reg == S_DATA) && out_free)
            out_vld_reg <= 1'b1;
        else if (rsp_fire)
            out_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_DATA) && out_free)
        begin
            out_oor_reg <= oor_reg;
            out_pix_reg <= oor_reg ? '0 : rd_data_reg;
        end
    end

    assign rsp.valid        = out_vld_reg;
    assign rsp.red_out      = out_pix_reg.red;
    assign rsp.green_out    = out_pix_reg.green;
    assign rsp.blue_out     = out_pix_reg.blue;
    assign rsp.out_of_range = out_oor_reg;

endmodule

`default_nettype wire

[hw/rtl/nnis_map.sv]
// Coordinate mapper: registered multiply of the output coordinate and the range check.
`default_nettype none

module nnis_map (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic [nnis_pkg::COORD_W-1:0] row,
    input  wire logic [nnis_pkg::COORD_W-1:0] col,
    input  wire nnis_pkg::scale_t             scale,
    input  wire logic [nnis_pkg::SIZE_W-1:0]  src_w,
    input  wire logic [nnis_pkg::SIZE_W-1:0]  src_h,
    output nnis_pkg::map_t                    result
);

    logic                          reduce_reg;
    logic [nnis_pkg::PROD_W-1:0]   row_prod_reg;
    logic [nnis_pkg::PROD_W-1:0]   col_prod_reg;
    logic [nnis_pkg::SRC_W-1:0]    src_row;
    logic [nnis_pkg::SRC_W-1:0]    src_col;

    // In enlarge mode the multiplier holds the reciprocal of the factor,
    // in reduce mode the factor itself.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            reduce_reg   <= scale.reduce;
            row_prod_reg <= nnis_pkg::PROD_W'(row) * nnis_pkg::PROD_W'(scale.mult);
            col_prod_reg <= nnis_pkg::PROD_W'(col) * nnis_pkg::PROD_W'(scale.mult);
        end
    end

    always_comb
    begin
        if (reduce_reg)
        begin
            src_row = row_prod_reg[nnis_pkg::SRC_W-1:0];
            src_col = col_prod_reg[nnis_pkg::SRC_W-1:0];
        end
        else
        begin
            src_row = nnis_pkg::SRC_W'(row_prod_reg >> nnis_pkg::RECIP_SHIFT);
            src_col = nnis_pkg::SRC_W'(col_prod_reg >> nnis_pkg::RECIP_SHIFT);
        end
    end

    // A coordinate beyond the scaled image always maps past the source edge,
    // so one compare per axis against the source size covers both modes.
    assign result.oor = (src_row >= nnis_pkg::SRC_W'(src_h)) ||
                        (src_col >= nnis_pkg::SRC_W'(src_w));
    assign result.row = src_row[nnis_pkg::ROW_BITS-1:0];
    assign result.col = src_col[nnis_pkg::COL_BITS-1:0];

endmodule

`default_nettype wire

[hw/rtl/nnis_checker.sv]
// Port-level checks of the image scaler and their binding to the top level.
`default_nettype none

module nnis_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              req_valid,
    input wire logic                              req_ready,
    input wire logic                              req_func,
    input wire logic                              rsp_valid,
    input wire logic                              rsp_ready,
    input wire logic [nnis_pkg::CHANNEL_BITS-1:0] rsp_red,
    input wire logic [nnis_pkg::CHANNEL_BITS-1:0] rsp_green,
    input wire logic [nnis_pkg::CHANNEL_BITS-1:0] rsp_blue,
    input wire logic                              rsp_oor
);

    logic read_fire;

    assign read_fire = req_valid && req_ready && (req_func == nnis_pkg::FUNC_READ);

    // A stalled result keeps its flag and samples.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_oor) &&
            $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
        else $error("stalled result changed");

    // An out-of-range result carries zero samples.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_oor |-> (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0))
        else $error("out-of-range result with nonzero samples");

    // A read blocks further requests while it is being mapped.
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        read_fire |=> !req_ready)
        else $error("request accepted during a read");

    // A result that appears on an empty output comes from a read that passed the map and data states without waiting.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(read_fire, 3))
        else $error("result without a matching read");

endmodule

bind nearest_neighbor_image_scaler nnis_checker u_nnis_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .req_func  (req.func),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_red   (rsp.red_out),
    .rsp_green (rsp.green_out),
    .rsp_blue  (rsp.blue_out),
    .rsp_oor   (rsp.out_of_range)
);

`default_nettype wire
